>>> rtl/core/cqsu_pkg.sv
// Shared constants, codes and control structures for the circular queue block.
`default_nettype none
package cqsu_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic                in_ready;
        logic                load;
        logic                push;
        logic                pop_done;
        logic                step;
        logic                wr_upd;
        logic                emit;
        logic                emit_data;
        logic                emit_last;
        logic [STATUS_W-1:0] emit_status;
    } t_cmd;

    typedef struct packed {
        logic              in_valid;
        logic [MODE_W-1:0] in_mode;
        logic              full;
        logic              empty;
        logic              match;
        logic              last_one;
        logic              out_free;
    } t_sts;

endpackage
`default_nettype wire

>>> rtl/core/cqsu_in_if.sv
// Input channel interface carrying one queue operation per transaction.
`default_nettype none
interface cqsu_in_if;
    logic                                valid;
    logic                                ready;
    logic [cqsu_pkg::MODE_W-1:0]         mode;
    logic signed [cqsu_pkg::DATA_W-1:0]  value;
    logic signed [cqsu_pkg::DATA_W-1:0]  new_value;

    modport source (output valid, output mode, output value, output new_value, input ready);
    modport sink   (input valid, input mode, input value, input new_value, output ready);
endinterface
`default_nettype wire

>>> rtl/core/cqsu_out_if.sv
// Output channel interface carrying one result per transaction.
`default_nettype none
interface cqsu_out_if;
    logic                                valid;
    logic                                ready;
    logic [cqsu_pkg::STATUS_W-1:0]       status;
    logic signed [cqsu_pkg::DATA_W-1:0]  data;
    logic                                last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/circular_queue_search_update_top.sv
// Push and empty-queue transactions give their result in the cycle after acceptance.
// A pop's result passes the registered storage read and then the result register; a dump of n
// entries gives its results the same way, one per cycle while the result is free, and an
// update walks up to n entries, both paced by the storage's single registered read port.
// A new transaction is taken only when the controller is idle and the result is free.
// Reset clears the pointers, the fill count and the controller; the storage is not cleared.
`default_nettype none
module circular_queue_search_update_top #(
    parameter int DEPTH = cqsu_pkg::DEPTH_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    cqsu_in_if.sink    i_in,
    cqsu_out_if.source o_out
);
    cqsu_pkg::t_cmd s_cmd;
    cqsu_pkg::t_sts s_sts;

    cqsu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd)
    );

    cqsu_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (s_cmd),
        .o_sts   (s_sts)
    );

    // A new result is never loaded over one that has not been taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.emit |-> s_sts.out_free)
        else $error("result register overwritten");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.push |-> !s_sts.full)
        else $error("push into a full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.wr_upd |-> (s_sts.match && !s_sts.empty))
        else $error("update written without a match");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.step || s_cmd.pop_done) |-> !s_cmd.in_ready)
        else $error("input accepted while a walk is in progress");

endmodule
`default_nettype wire

>>> rtl/core/cqsu_datapath.sv
// Queue storage, pointers, walk counter and output register of the circular queue.
`default_nettype none
module cqsu_datapath #(
    parameter int DEPTH = cqsu_pkg::DEPTH_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    cqsu_in_if.sink        i_in,
    cqsu_out_if.source     o_out,
    input  cqsu_pkg::t_cmd i_cmd,
    output cqsu_pkg::t_sts o_sts
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [cqsu_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [cqsu_pkg::DATA_W-1:0] r_rdata;
    logic signed [cqsu_pkg::DATA_W-1:0] r_key;
    logic signed [cqsu_pkg::DATA_W-1:0] r_new;
    logic [AW-1:0]                      r_head;
    logic [AW-1:0]                      r_tail;
    logic [AW-1:0]                      r_ptr;
    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      r_left;
    logic                               r_out_valid;
    logic [cqsu_pkg::STATUS_W-1:0]      r_out_status;
    logic signed [cqsu_pkg::DATA_W-1:0] r_out_data;
    logic                               r_out_last;

    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;
    logic [AW-1:0] n_ptr;
    logic [AW-1:0] n_rd_addr;

    always_comb begin
        n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
        n_tail = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + AW'(1);
        n_ptr  = (r_ptr == AW'(DEPTH - 1)) ? '0 : r_ptr + AW'(1);
        if (i_cmd.load) begin
            n_rd_addr = r_head;
        end else if (i_cmd.step) begin
            n_rd_addr = n_ptr;
        end else begin
            n_rd_addr = r_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_tail] <= i_in.value;
        end else if (i_cmd.wr_upd) begin
            r_mem[r_ptr] <= r_new;
        end
        r_rdata <= r_mem[n_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_in.value;
            r_new <= i_in.new_value;
        end
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_data   <= i_cmd.emit_data ? r_rdata : '0;
            r_out_last   <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_ptr       <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_tail  <= n_tail;
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop_done) begin
                r_head  <= n_head;
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.load) begin
                r_ptr  <= r_head;
                r_left <= r_count;
            end else if (i_cmd.step) begin
                r_ptr  <= n_ptr;
                r_left <= r_left - CW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_in.ready   = i_cmd.in_ready;
    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out_status;
    assign o_out.data   = r_out_data;
    assign o_out.last   = r_out_last;

    always_comb begin
        o_sts.in_valid = i_in.valid;
        o_sts.in_mode  = i_in.mode;
        o_sts.full     = (r_count == CW'(DEPTH));
        o_sts.empty    = (r_count == '0);
        o_sts.match    = (r_rdata == r_key);
        o_sts.last_one = (r_left == CW'(1));
        o_sts.out_free = !r_out_valid || o_out.ready;
    end

endmodule
`default_nettype wire

>>> rtl/core/cqsu_ctrl.sv
// Controller state machine that sequences push, pop, dump and update transactions.
`default_nettype none
module cqsu_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  cqsu_pkg::t_sts i_sts,
    output cqsu_pkg::t_cmd o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = i_sts.out_free;
                if (i_sts.in_valid && i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    if (i_sts.in_mode == cqsu_pkg::MODE_PUSH) begin
                        if (i_sts.full) begin
                            o_cmd.emit_status = cqsu_pkg::ST_FULL;
                        end else begin
                            o_cmd.push        = 1'b1;
                            o_cmd.emit_status = cqsu_pkg::ST_OK;
                        end
                    end else if (i_sts.empty) begin
                        o_cmd.emit_status = cqsu_pkg::ST_EMPTY;
                    end else begin
                        o_cmd.emit = 1'b0;
                        o_cmd.load = 1'b1;
                        case (i_sts.in_mode)
                            cqsu_pkg::MODE_POP:  n_state = S_POP;
                            cqsu_pkg::MODE_DUMP: n_state = S_DUMP;
                            default:             n_state = S_UPD;
                        endcase
                    end
                end
            end
            S_POP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_data   = 1'b1;
                    o_cmd.emit_last   = 1'b1;
                    o_cmd.emit_status = cqsu_pkg::ST_OK;
                    o_cmd.pop_done    = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_DUMP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_data   = 1'b1;
                    o_cmd.emit_last   = i_sts.last_one;
                    o_cmd.emit_status = cqsu_pkg::ST_OK;
                    if (i_sts.last_one) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            S_UPD: begin
                if (i_sts.match) begin
                    if (i_sts.out_free) begin
                        o_cmd.wr_upd      = 1'b1;
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_last   = 1'b1;
                        o_cmd.emit_status = cqsu_pkg::ST_OK;
                        n_state           = S_IDLE;
                    end
                end else if (!i_sts.last_one) begin
                    o_cmd.step = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_last   = 1'b1;
                    o_cmd.emit_status = cqsu_pkg::ST_NOT_FOUND;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> tb/circular_queue_search_update_top_tb.sv
// Self-checking testbench for the circular queue with push, pop, dump and search-and-replace.
`timescale 1ns / 1ps
module circular_queue_search_update_top_tb;

    localparam int QDEPTH      = cqsu_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 3 * QDEPTH + 8;

    typedef struct {
        logic [cqsu_pkg::MODE_W-1:0]        mode;
        logic signed [cqsu_pkg::DATA_W-1:0] value;
        logic signed [cqsu_pkg::DATA_W-1:0] new_value;
    } t_queue_op;

    typedef struct {
        logic [cqsu_pkg::STATUS_W-1:0]      status;
        logic signed [cqsu_pkg::DATA_W-1:0] data;
        logic                               last;
    } t_queue_result;

    logic i_clk;
    logic i_rst_n;

    cqsu_in_if  in_if ();
    cqsu_out_if out_if ();

    circular_queue_search_update_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_queue_op     ops_pending[$];
    t_queue_result results_due[$];

    logic signed [cqsu_pkg::DATA_W-1:0] shadow_entries [QDEPTH];
    int                                 shadow_head;
    int                                 shadow_tail;
    int                                 shadow_fill;

    int ops_total;
    int ops_accepted;
    int mismatch_count;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;

    logic signed [cqsu_pkg::DATA_W-1:0] key_pool [8];

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    task automatic due_result(input logic [cqsu_pkg::STATUS_W-1:0] status,
                              input logic signed [cqsu_pkg::DATA_W-1:0] data,
                              input logic last);
        t_queue_result res;
        res.status = status;
        res.data   = data;
        res.last   = last;
        results_due.push_back(res);
    endtask

    task automatic model_queue_op(input t_queue_op op);
        int  k;
        int  idx;
        bit  hit;
        hit = 1'b0;
        if (op.mode == cqsu_pkg::MODE_PUSH) begin
            if (shadow_fill == QDEPTH) begin
                due_result(cqsu_pkg::ST_FULL, '0, 1'b1);
            end else begin
                shadow_entries[shadow_tail] = op.value;
                shadow_tail = (shadow_tail + 1) % QDEPTH;
                shadow_fill++;
                due_result(cqsu_pkg::ST_OK, '0, 1'b1);
            end
        end else if (shadow_fill == 0) begin
            due_result(cqsu_pkg::ST_EMPTY, '0, 1'b1);
        end else if (op.mode == cqsu_pkg::MODE_POP) begin
            due_result(cqsu_pkg::ST_OK, shadow_entries[shadow_head], 1'b1);
            shadow_head = (shadow_head + 1) % QDEPTH;
            shadow_fill--;
        end else if (op.mode == cqsu_pkg::MODE_DUMP) begin
            for (k = 0; k < shadow_fill; k++) begin
                idx = (shadow_head + k) % QDEPTH;
                due_result(cqsu_pkg::ST_OK, shadow_entries[idx], k == shadow_fill - 1);
            end
        end else begin
            for (k = 0; k < shadow_fill && !hit; k++) begin
                idx = (shadow_head + k) % QDEPTH;
                if (shadow_entries[idx] == op.value) begin
                    shadow_entries[idx] = op.new_value;
                    hit = 1'b1;
                end
            end
            due_result(hit ? cqsu_pkg::ST_OK : cqsu_pkg::ST_NOT_FOUND, '0, 1'b1);
        end
    endtask

    task automatic queue_op(input logic [cqsu_pkg::MODE_W-1:0] mode,
                            input logic signed [cqsu_pkg::DATA_W-1:0] value,
                            input logic signed [cqsu_pkg::DATA_W-1:0] new_value);
        t_queue_op op;
        op.mode      = mode;
        op.value     = value;
        op.new_value = new_value;
        ops_pending.push_back(op);
    endtask

    task automatic build_stimulus();
        int seg;
        int n;
        int push_pct;
        int r;
        logic [cqsu_pkg::MODE_W-1:0] mode;
        logic signed [cqsu_pkg::DATA_W-1:0] value;
        logic signed [cqsu_pkg::DATA_W-1:0] new_value;

        queue_op(cqsu_pkg::MODE_POP, 32'sd0, 32'sd0);
        queue_op(cqsu_pkg::MODE_DUMP, 32'sd0, 32'sd0);
        queue_op(cqsu_pkg::MODE_UPDATE, 32'sd0, 32'sd1);
        queue_op(cqsu_pkg::MODE_PUSH, 32'h7fff_ffff, 32'sd0);
        queue_op(cqsu_pkg::MODE_PUSH, 32'h8000_0000, 32'sd0);
        queue_op(cqsu_pkg::MODE_PUSH, 32'sd0, 32'sd0);
        queue_op(cqsu_pkg::MODE_PUSH, -32'sd1, 32'sd0);
        queue_op(cqsu_pkg::MODE_PUSH, 32'h5555_5555, 32'sd0);
        queue_op(cqsu_pkg::MODE_PUSH, 32'haaaa_aaaa, 32'sd0);
        queue_op(cqsu_pkg::MODE_PUSH, 32'sd0, 32'sd0);
        queue_op(cqsu_pkg::MODE_PUSH, 32'sd12345, 32'sd0);
        queue_op(cqsu_pkg::MODE_PUSH, 32'sd1, 32'sd0);
        queue_op(cqsu_pkg::MODE_DUMP, 32'sd0, 32'sd0);
        queue_op(cqsu_pkg::MODE_UPDATE, 32'sd0, 32'sd77);
        queue_op(cqsu_pkg::MODE_UPDATE, 32'sd999, 32'sd5);
        queue_op(cqsu_pkg::MODE_POP, 32'sd0, 32'sd0);
        queue_op(cqsu_pkg::MODE_POP, 32'sd0, 32'sd0);
        queue_op(cqsu_pkg::MODE_PUSH, 32'h1357_9bdf, 32'sd0);
        queue_op(cqsu_pkg::MODE_PUSH, -32'sd2, 32'sd0);
        queue_op(cqsu_pkg::MODE_UPDATE, -32'sd2, 32'h7fff_ffff);
        queue_op(cqsu_pkg::MODE_UPDATE, 32'sd0, 32'h8000_0000);
        queue_op(cqsu_pkg::MODE_DUMP, 32'sd0, 32'sd0);
        queue_op(cqsu_pkg::MODE_POP, 32'sd0, 32'sd0);
        queue_op(cqsu_pkg::MODE_DUMP, 32'sd0, 32'sd0);

        key_pool[0] = 32'h7fff_ffff;
        key_pool[1] = 32'h8000_0000;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        for (n = 4; n < 8; n++) key_pool[n] = $urandom;

        for (seg = 0; seg < 19; seg++) begin
            push_pct = $urandom_range(10, 80);
            key_pool[$urandom_range(0, 7)] = $urandom;
            for (n = 0; n < 20; n++) begin
                r = $urandom_range(0, 99);
                if (r < push_pct) begin
                    mode = cqsu_pkg::MODE_PUSH;
                end else begin
                    case ($urandom_range(0, 2))
                        0: mode = cqsu_pkg::MODE_POP;
                        1: mode = cqsu_pkg::MODE_DUMP;
                        default: mode = cqsu_pkg::MODE_UPDATE;
                    endcase
                end
                value     = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 7)]
                                                        : $urandom;
                new_value = $urandom_range(0, 1) ? key_pool[$urandom_range(0, 7)] : $urandom;
                queue_op(mode, value, new_value);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                model_queue_op('{in_if.mode, in_if.value, in_if.new_value});
                ops_accepted++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (ops_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_if.valid     <= 1'b1;
                    in_if.mode      <= ops_pending[0].mode;
                    in_if.value     <= ops_pending[0].value;
                    in_if.new_value <= ops_pending[0].new_value;
                    ops_pending.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: status %0d data %0d last %0b",
                                 out_if.status, out_if.data, out_if.last);
                end else begin
                    if (out_if.status !== results_due[0].status
                            || out_if.data !== results_due[0].data
                            || out_if.last !== results_due[0].last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: expected status %0d data %0d last %0b,",
                                      " got status %0d data %0d last %0b"},
                                     results_due[0].status, results_due[0].data,
                                     results_due[0].last,
                                     out_if.status, out_if.data, out_if.last);
                    end
                    results_due.pop_front();
                end
            end
            out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (ops_accepted < ops_total / 3) begin
            send_idle_pct <= 23;
            recv_idle_pct <= 77;
        end else if (ops_accepted < 2 * ops_total / 3) begin
            send_idle_pct <= 77;
            recv_idle_pct <= 23;
        end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("circular_queue_search_update_top regression: fail");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.mode       = cqsu_pkg::MODE_PUSH;
        in_if.value      = '0;
        in_if.new_value  = '0;
        out_if.ready     = 1'b0;
        ops_accepted     = 0;
        mismatch_count   = 0;
        send_idle_pct    = 23;
        recv_idle_pct    = 77;
        shadow_head      = 0;
        shadow_tail      = 0;
        shadow_fill      = 0;
        build_stimulus();
        ops_total = ops_pending.size();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (ops_accepted < ops_total || results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("circular_queue_search_update_top regression: pass");
        end else begin
            $display("circular_queue_search_update_top regression: fail");
        end
        $finish;
    end

endmodule
